// ----- rtl/core/rmth_pkg.sv -----
`default_nettype none
package rmth_pkg;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } heap_op_t;

  // Command from controller to datapath
  typedef struct packed {
    heap_op_t op;
    logic     sel_upper;   // 1: min-heap (upper), 0: max-heap (lower)
    logic     src_moved;   // push value: 1 moved top, 0 sample
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

  localparam logic [0:0] REG_MAX_OBS = 1'd0;

endpackage
`default_nettype wire

// ----- rtl/core/rmth_ram.sv -----
`default_nettype none
module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 513
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/rmth_datapath.sv -----
`default_nettype none
module rmth_datapath
  import rmth_pkg::*;
#(
  parameter int VB = 32,
  parameter int DEPTH = 513,
  parameter int AW = 10,
  parameter int CW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire dp_cmd_t       cmd,
  input  wire logic [VB-1:0] sample,
  output dp_status_t         status,
  output logic [CW-1:0]      lcount,
  output logic [CW-1:0]      ucount,
  output logic [VB-1:0]      ltop,
  output logic [VB-1:0]      utop
);
  // Each sift step has two states: issue read(s), then compare and swap.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PUSHR  = 6'b000010,
    S_PUSHC  = 6'b000100,
    S_POPR   = 6'b001000,
    S_POPC   = 6'b010000,
    S_POPW   = 6'b100000
  } dst_t;

  dst_t state;
  logic is_up;
  logic [AW-1:0] idx, n;
  logic [VB-1:0] cur, moved;
  logic          we;
  logic [AW-1:0] wa, ra0, ra1;
  logic [VB-1:0] wd;
  logic [VB-1:0] rl0, rl1, ru0, ru1, r0, r1;
  logic          use_b;

  // Two RAMs per heap so a pop step reads both children in the same cycle.
  rmth_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_l0 (.clk, .we(we && !is_up), .waddr(wa),
    .wdata(wd), .raddr(ra0), .rdata(rl0));
  rmth_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_l1 (.clk, .we(we && !is_up), .waddr(wa),
    .wdata(wd), .raddr(ra1), .rdata(rl1));
  rmth_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_u0 (.clk, .we(we && is_up), .waddr(wa),
    .wdata(wd), .raddr(ra0), .rdata(ru0));
  rmth_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_u1 (.clk, .we(we && is_up), .waddr(wa),
    .wdata(wd), .raddr(ra1), .rdata(ru1));

  assign r0 = is_up ? ru0 : rl0;
  assign r1 = is_up ? ru1 : rl1;

  function automatic logic first(input logic [VB-1:0] a, input logic [VB-1:0] b,
                                 input logic up);
    first = up ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
  endfunction

  logic [AW-1:0] par;
  logic [AW:0]   lch, rch;
  logic          has_l, has_r;
  logic [VB-1:0] best;
  logic [AW-1:0] bidx;
  assign par   = AW'((idx - AW'(1)) >> 1);
  assign lch   = {idx, 1'b1};
  assign rch   = lch + (AW+1)'(1);
  assign has_l = (lch < {1'b0, n});
  assign has_r = (rch < {1'b0, n});
  assign use_b = has_r && first(r1, r0, is_up);
  assign best  = use_b ? r1 : r0;
  assign bidx  = use_b ? AW'(rch) : AW'(lch);

  always_comb begin
    we = 1'b0; wa = idx; wd = cur; ra0 = '0; ra1 = '0;
    unique case (state)
      S_PUSHR: ra0 = par;
      S_PUSHC: begin
        we = 1'b1;
        if (idx != '0 && first(cur, r0, is_up)) begin
          wd = r0;
        end
      end
      S_POPW: begin
        we = 1'b1; wa = '0;
      end
      S_POPR: begin
        ra0 = AW'(lch); ra1 = AW'(rch);
      end
      S_POPC: begin
        we = 1'b1;
        if (has_l && first(best, cur, is_up)) wd = best;
      end
      default: ra0 = cmd.sel_upper ? AW'(ucount - CW'(1)) : AW'(lcount - CW'(1));
    endcase
  end

  // ra0 default reads last entry of the selected heap for a pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; lcount <= '0; ucount <= '0; status <= '0;
    end else begin
      status.done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          is_up <= cmd.sel_upper;
          if (cmd.op == OP_PUSH) begin
            idx <= cmd.sel_upper ? AW'(ucount) : AW'(lcount);
            cur <= cmd.src_moved ? moved : sample;
            if (cmd.sel_upper) ucount <= ucount + CW'(1);
            else lcount <= lcount + CW'(1);
            state <= S_PUSHR;
          end else if (cmd.op == OP_POP) begin
            moved <= cmd.sel_upper ? utop : ltop;
            n <= cmd.sel_upper ? AW'(ucount - CW'(1)) : AW'(lcount - CW'(1));
            if (cmd.sel_upper) ucount <= ucount - CW'(1);
            else lcount <= lcount - CW'(1);
            state <= S_POPW;
          end else begin
            status.done <= 1'b1;
          end
        end
        S_PUSHR: state <= S_PUSHC;
        S_PUSHC: begin
          if (idx != '0 && first(cur, r0, is_up)) begin
            idx <= par; state <= S_PUSHR;
          end else begin
            if (idx == '0) begin
              if (is_up) utop <= cur; else ltop <= cur;
            end
            state <= S_IDLE; status.done <= 1'b1;
          end
        end
        S_POPW: begin
          // wait one read: last entry arrives and is captured as the new root value
          state <= S_POPR; idx <= '0;
        end
        S_POPR: state <= S_POPC;
        S_POPC: begin
          if (idx == '0) begin
            if (has_l && first(best, cur, is_up)) begin
              if (is_up) utop <= best; else ltop <= best;
            end else begin
              if (is_up) utop <= cur; else ltop <= cur;
            end
          end
          if (has_l && first(best, cur, is_up)) begin
            idx <= bidx; state <= S_POPR;
          end else begin
            state <= S_IDLE; status.done <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      // capture the last entry read in S_IDLE for the pop's new root
      if (state == S_POPW) cur <= r0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/rmth_ctrl.sv -----
`default_nettype none
module rmth_ctrl
  import rmth_pkg::*;
#(
  parameter int VB = 32,
  parameter int CW = 10,
  parameter int MAX_OBS = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [VB-1:0] sample,
  output logic [VB-1:0]      held_sample,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [VB:0]        median,
  output logic               stat,
  input  wire logic [10:0]   max_obs,
  output logic               start,
  output dp_cmd_t            cmd,
  input  wire dp_status_t    dstat,
  input  wire logic [CW-1:0] lcount,
  input  wire logic [CW-1:0] ucount,
  input  wire logic [VB-1:0] ltop,
  input  wire logic [VB-1:0] utop
);
  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_OP1  = 5'b00010,
    C_OP2  = 5'b00100,
    C_WAIT = 5'b01000,
    C_DONE = 5'b10000
  } cst_t;

  cst_t state;
  logic [VB:0] last;
  logic [1:0]  ops;   // ops left
  dp_cmd_t     c1, c2, c3;

  localparam int EW = $clog2(MAX_OBS + 1) + 1;
  logic [EW-1:0] eff, lcap, ucap, nl, nu;
  logic below, lheavy, rheavy, reject;

  always_comb begin
    eff = ({21'd0, max_obs} > 32'(MAX_OBS)) ? EW'(MAX_OBS) : EW'(max_obs);
    lcap = eff >> 1;
    ucap = lcap + EW'(1);
    below = $signed({sample, 1'b0}) < $signed(last);
    lheavy = ({1'b0, lcount} == {1'b0, ucount} + 1'b1);
    rheavy = ({1'b0, ucount} == {1'b0, lcount} + 1'b1);
    nl = EW'(lcount); nu = EW'(ucount);
    if (lheavy) nu = nu + EW'(1);
    else if (rheavy) nl = nl + EW'(1);
    else if (below) nl = nl + EW'(1);
    else nu = nu + EW'(1);
    reject = (nl > lcap) || (nu > ucap);
  end

  assign in_ready = (state == C_IDLE) && !out_valid;
  assign cmd = c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE; out_valid <= 1'b0; last <= '0; start <= 1'b0;
    end else begin
      start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        C_IDLE: if (in_valid && in_ready) begin
          held_sample <= sample;
          if (reject) begin
            median <= last; stat <= 1'b1; out_valid <= 1'b1;
          end else begin
            stat <= 1'b0;
            if (lheavy && below) begin
              c1 <= '{OP_POP, 1'b0, 1'b0};
              c2 <= '{OP_PUSH, 1'b1, 1'b1};
              c3 <= '{OP_PUSH, 1'b0, 1'b0}; ops <= 2'd2;
            end else if (rheavy && !below) begin
              c1 <= '{OP_POP, 1'b1, 1'b0};
              c2 <= '{OP_PUSH, 1'b0, 1'b1};
              c3 <= '{OP_PUSH, 1'b1, 1'b0}; ops <= 2'd2;
            end else begin
              c1 <= '{OP_PUSH, rheavy ? 1'b0 : (lheavy ? 1'b1 : !below), 1'b0};
              ops <= 2'd0;
            end
            state <= C_OP1;
          end
        end
        C_OP1: begin
          start <= 1'b1; state <= C_WAIT;
        end
        C_OP2: begin
          start <= 1'b1; state <= C_WAIT;
        end
        C_WAIT: if (dstat.done) begin
          if (ops != 2'd0) begin
            c1 <= c2; c2 <= c3; ops <= ops - 2'd1; state <= C_OP2;
          end else state <= C_DONE;
        end
        C_DONE: begin
          if (lcount == ucount)
            median <= (VB+1)'($signed(ltop)) + (VB+1)'($signed(utop));
          else if (lcount > ucount) median <= {ltop, 1'b0};
          else median <= {utop, 1'b0};
          if (lcount == ucount)
            last <= (VB+1)'($signed(ltop)) + (VB+1)'($signed(utop));
          else if (lcount > ucount) last <= {ltop, 1'b0};
          else last <= {utop, 1'b0};
          out_valid <= 1'b1; state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  ap_one_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != C_IDLE) |-> !in_ready) else $error("accept while busy");
  ap_start_wait: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == C_WAIT)) else $error("start outside wait");
endmodule
`default_nettype wire

// ----- rtl/core/running_median_two_heaps_top.sv -----
// A rejected request returns the last median without any heap operation.
// Each heap push or pop sifts one level per step (read, then compare and write) through the heap RAMs.
// One request at a time: up to three sifts (pop, push, push) of about ten levels each.
// Reset (rst, synchronous) clears counts, last median and sets max_observations to 1024.
// Heap RAM contents are not cleared; only entries below the counts are read.
`default_nettype none
module running_median_two_heaps_top
  import rmth_pkg::*;
#(
  parameter int MAX_OBS = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata, // sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [((VALUE_BITS+1+7)/8)*8-1:0] m_tdata,    // median_doubled
  output logic             m_tuser,                     // status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int DEPTH = MAX_OBS / 2 + 1;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = ((VALUE_BITS+1+7)/8)*8;

  logic [10:0] max_obs;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_obs <= 11'd1024;
    else if (psel && penable && pwrite && paddr == 2'({REG_MAX_OBS, 2'b00}))
      max_obs <= pwdata[10:0];
  end
  assign prdata = (paddr == 2'({REG_MAX_OBS, 2'b00})) ? {21'd0, max_obs} : 32'd0;

  logic start;
  dp_cmd_t cmd;
  dp_status_t dstat;
  logic [CW-1:0] lcount, ucount;
  logic [VALUE_BITS-1:0] ltop, utop;
  logic [VALUE_BITS-1:0] held_sample;
  logic [VALUE_BITS:0] median;

  rmth_ctrl #(.VB(VALUE_BITS), .CW(CW), .MAX_OBS(MAX_OBS)) u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .sample(s_tdata[VALUE_BITS-1:0]), .held_sample,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .median, .stat(m_tuser), .max_obs, .start, .cmd, .dstat,
    .lcount, .ucount, .ltop, .utop);

  rmth_datapath #(.VB(VALUE_BITS), .DEPTH(DEPTH), .AW(AW), .CW(CW)) u_dp (
    .clk, .rst, .start, .cmd, .sample(held_sample), .status(dstat),
    .lcount, .ucount, .ltop, .utop);

  assign m_tdata = OW'({{(OW-VALUE_BITS-1){1'b0}}, median});
endmodule
`default_nettype wire
